// File: src/slot_pool_allocator_unit_defines.svh
// Assertion macros used by the slot pool allocator RTL.
`ifndef SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define SPA_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define SPA_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SPA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/spa_pkg.sv
// Shared types and codes of the slot pool allocator.
package spa_pkg;

  localparam int ROW_W  = 16;
  localparam int ROW_PW = 4;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;

  typedef struct packed {
    logic              found;
    logic [ROW_PW-1:0] pos;
  } scan_t;

endpackage

// File: src/spa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module spa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/spa_row_scan.sv
// Finds the lowest cleared valid bit of one row inside a window of positions.
module spa_row_scan (
  input  logic [spa_pkg::ROW_W-1:0]  row_bits,
  input  logic [spa_pkg::ROW_PW:0]   lo,
  input  logic [spa_pkg::ROW_PW:0]   hi,
  output spa_pkg::scan_t             res
);
  import spa_pkg::*;

  logic [ROW_W-1:0] cand;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      cand[i] = !row_bits[i] && ((ROW_PW+1)'(i) >= lo) && ((ROW_PW+1)'(i) < hi);
    end
  end

  // Walk from the top down so the lowest candidate wins.
  always_comb begin
    res = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.found = 1'b1;
        res.pos   = ROW_PW'(i);
      end
    end
  end

endmodule

// File: src/slot_pool_allocator_unit.sv
// Top level of the slot pool allocator: sequencer, valid-row and data memories.
//
//   channel   ports                                             handshake
//   request   op, slot, write_data                              start / busy
//   result    status, result_slot, read_data, live_count,       done (one cycle)
//             used_slots
//
// A request has a memory read, issued when it is accepted, then the check and write-back
// cycle in ST_RD; its result is strobed on done in the cycle after that.
// An add that fills a hole then searches for the next hole, one valid row of 16
// slots per cycle, and stays busy until a hole is found or the mark is reached.
// Valid rows are only trusted below the high-water mark, so reset needs no
// clearing pass; rst clears the counts and the sequencer.
// Results cannot be held off: done is high for exactly one cycle per request.
`include "slot_pool_allocator_unit_defines.svh"

module slot_pool_allocator_unit #(
  parameter int SLOTS      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [5:0]  slot,
  input  logic [31:0] write_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  result_slot,
  output logic [31:0] read_data,
  output logic [6:0]  live_count,
  output logic [6:0]  used_slots
);
  import spa_pkg::*;

  localparam int ROWS   = (SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW     = ROW_AW + ROW_PW + 1;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]            state, state_next;
  logic [CNT_W-1:0]      hw, hw_next;
  logic [CNT_W-1:0]      hole, hole_next;
  logic [CNT_W-1:0]      live, live_next;
  logic [1:0]            cur_op;
  logic [5:0]            cur_slot;
  logic [DATA_WIDTH-1:0] cur_wdata;
  logic [XW-1:0]         cur_tgt;
  logic [ROW_AW-1:0]     row, row_next;

  logic                  accept;
  logic [XW-1:0]         req_tgt;
  logic [ROW_AW-1:0]     req_row;
  logic [XW-1:0]         base_x, hw_x, found_x;
  logic [ROW_PW-1:0]     tgt_pos;
  logic [ROW_PW:0]       hi, lo;
  logic [ROW_W-1:0]      hi_mask, vrow, bit_sel;
  logic                  row_last;
  scan_t                 scan;

  logic                  v_we;
  logic [ROW_W-1:0]      v_wdata, v_rdata;
  logic [ROW_AW-1:0]     v_raddr;
  logic                  d_we;
  logic [DATA_WIDTH-1:0] d_rdata;

  logic                  done_next;
  logic [1:0]            res_status;
  logic [5:0]            res_slot;
  logic [31:0]           res_data;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // An add targets the lowest hole, which equals the mark when there is none.
  assign req_tgt = (op == OP_ADD) ? XW'(hole) : XW'(slot);
  assign req_row = req_tgt[XW-2:ROW_PW];

  assign base_x   = XW'({row, {ROW_PW{1'b0}}});
  assign hw_x     = XW'(hw);
  assign tgt_pos  = cur_tgt[ROW_PW-1:0];
  assign found_x  = base_x + XW'(scan.pos);
  assign row_last = (base_x + XW'(ROW_W)) >= hw_x;
  assign bit_sel  = ROW_W'(1) << tgt_pos;

  // Positions of the current row that lie below the high-water mark.
  always_comb begin
    if (hw_x >= base_x + XW'(ROW_W)) begin
      hi = (ROW_PW+1)'(ROW_W);
    end else if (hw_x > base_x) begin
      hi = (ROW_PW+1)'(hw_x - base_x);
    end else begin
      hi = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      hi_mask[i] = (ROW_PW+1)'(i) < hi;
    end
  end

  // Bits at or above the mark were never written and are ignored.
  assign vrow = v_rdata & hi_mask;

  assign lo = (state == ST_RD) ? (ROW_PW+1)'({1'b0, tgt_pos} + 1'b1) : '0;

  spa_row_scan u_scan (
    .row_bits (vrow),
    .lo       (lo),
    .hi       (hi),
    .res      (scan)
  );

  assign v_raddr = (state == ST_IDLE) ? req_row : ROW_AW'(row + 1'b1);

  spa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (row),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  spa_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (cur_tgt[IDX_W-1:0]),
    .wdata (cur_wdata),
    .raddr (req_tgt[IDX_W-1:0]),
    .rdata (d_rdata)
  );

  always_comb begin
    state_next = state;
    hw_next    = hw;
    hole_next  = hole;
    live_next  = live;
    row_next   = row;
    v_we       = 1'b0;
    v_wdata    = vrow;
    d_we       = 1'b0;
    done_next  = 1'b0;
    res_status = STAT_OK;
    res_slot   = cur_slot;
    res_data   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          row_next   = req_row;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        case (cur_op) inside
          OP_ADD: begin
            if (hole < hw) begin
              v_we      = 1'b1;
              v_wdata   = vrow | bit_sel;
              d_we      = 1'b1;
              live_next = CNT_W'(live + 1'b1);
              res_slot  = 6'(cur_tgt);
              if (scan.found) begin
                hole_next = CNT_W'(found_x);
              end else if (row_last) begin
                hole_next = hw;
              end else begin
                state_next = ST_SCAN;
                row_next   = ROW_AW'(row + 1'b1);
              end
            end else if (hw != CNT_W'(SLOTS)) begin
              v_we      = 1'b1;
              v_wdata   = vrow | bit_sel;
              d_we      = 1'b1;
              hw_next   = CNT_W'(hw + 1'b1);
              hole_next = CNT_W'(hw + 1'b1);
              live_next = CNT_W'(live + 1'b1);
              res_slot  = 6'(cur_tgt);
            end else begin
              res_status = STAT_FULL;
            end
          end
          OP_POP, OP_READ: begin
            if (cur_tgt >= hw_x) begin
              res_status = STAT_RANGE;
            end else if (!vrow[tgt_pos]) begin
              res_status = STAT_INVALID;
            end else if (cur_op == OP_POP) begin
              v_we      = 1'b1;
              v_wdata   = vrow & ~bit_sel;
              live_next = CNT_W'(live - 1'b1);
              if (cur_tgt < XW'(hole)) begin
                hole_next = CNT_W'(cur_tgt);
              end
            end else begin
              res_data = 32'(d_rdata);
            end
          end
          default: begin
            res_status = STAT_OK;
          end
        endcase
      end
      ST_SCAN: begin
        if (scan.found) begin
          hole_next  = CNT_W'(found_x);
          state_next = ST_IDLE;
        end else if (row_last) begin
          hole_next  = hw;
          state_next = ST_IDLE;
        end else begin
          row_next = ROW_AW'(row + 1'b1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hw    <= '0;
      hole  <= '0;
      live  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      hw    <= hw_next;
      hole  <= hole_next;
      live  <= live_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
    if (accept) begin
      cur_op    <= op;
      cur_slot  <= slot;
      cur_wdata <= DATA_WIDTH'(write_data);
      cur_tgt   <= req_tgt;
    end
    if (done_next) begin
      status      <= res_status;
      result_slot <= res_slot;
      read_data   <= res_data;
      live_count  <= 7'(live_next);
      used_slots  <= 7'(hw_next);
    end
  end

  `SPA_CHECK(a_live_le_hw, live <= hw, "live count above high-water mark")
  `SPA_CHECK(a_hole_le_hw, hole <= hw, "hole pointer above high-water mark")
  `SPA_IMPLY(a_done_after_rd, done, $past(state) == ST_RD, "result without a check cycle")
  `SPA_NEXT(a_busy_after_accept, accept, busy, "request accepted but block not busy")

endmodule
